@@ src/tlbpt_pkg.sv @@
`timescale 1ns / 1ps

package tlbpt_pkg;

    // address split: page number in the upper byte, offset in the lower byte
    localparam int VA_W       = 16;
    localparam int PA_W       = 16;
    localparam int OFFSET_W   = 8;
    localparam int PAGE_W     = 8;
    localparam int FRAME_W    = 8;
    localparam int PAGE_COUNT = 256;
    localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);

    // default translation buffer depth
    localparam int TLB_ENTRIES_DEF = 16;

    // one translation buffer entry, moved from cell to cell
    typedef struct packed {
        logic [PAGE_W-1:0]  tag;
        logic [FRAME_W-1:0] frame;
    } t_xlat_entry;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;  // take the entry of the left neighbor
        logic valid;  // cell holds a live entry
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

@@ src/tlbpt_cell.sv @@
`timescale 1ns / 1ps

module tlbpt_cell (
    input  logic                       i_clk,
    input  tlbpt_pkg::t_cell_ctl       i_ctl,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  i_key,
    input  tlbpt_pkg::t_xlat_entry     i_entry,
    output tlbpt_pkg::t_xlat_entry     o_entry,
    output logic                       o_hit,
    output logic [tlbpt_pkg::FRAME_W-1:0] o_frame
);
    import tlbpt_pkg::*;

    t_xlat_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_entry;
        end
    end

    // compare against the lookup key, frame masked to zero on a miss
    assign o_hit   = i_ctl.valid && (r_entry.tag == i_key);
    assign o_frame = o_hit ? r_entry.frame : '0;
    assign o_entry = r_entry;

endmodule

@@ src/tlbpt_page_map.sv @@
`timescale 1ns / 1ps

module tlbpt_page_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [tlbpt_pkg::PAGE_IDX_W-1:0]  i_rd_page,
    output logic                              o_rd_valid,
    output logic [tlbpt_pkg::FRAME_W-1:0]     o_rd_frame,
    input  logic                              i_wr_en,
    input  logic [tlbpt_pkg::PAGE_IDX_W-1:0]  i_wr_page,
    input  logic [tlbpt_pkg::FRAME_W-1:0]     i_wr_frame
);
    import tlbpt_pkg::*;

    logic [FRAME_W-1:0]  r_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_valid;
    logic                r_rd_valid;
    logic [FRAME_W-1:0]  r_rd_frame;

    // frame storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_page] <= i_wr_frame;
        end
        if (i_rd_en) begin
            r_rd_frame <= r_mem[i_rd_page];
            r_rd_valid <= r_valid[i_rd_page];
        end
    end

    // per-page valid flags, all cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_page] <= 1'b1;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_frame = r_rd_frame;

endmodule

@@ src/tlb_page_table_translator.sv @@
`timescale 1ns / 1ps

// Virtual to physical address translator. Each transfer on the slave side carries a
// 16-bit virtual address (page in the upper byte, offset in the lower byte) and gives
// exactly one transfer on the master side with the 16-bit physical address and two
// flags: tlb_hit when the page was found in the translation buffer, fault when
// the page had no mapping and the next frame of a wrapping 8-bit counter was given to
// it. A page that misses the buffer but is mapped, or that faults, is put into the
// buffer; once full, the buffer drops its oldest entry. The buffer is a row of
// TLB_ENTRIES cells that shifts by one on every insert, so the newest entry sits in
// cell 0 and the oldest falls off the far end; all cells compare the page at once.
// The 256-entry page map is a memory with per-page valid flags cleared by reset, so
// the block is ready right after reset. Each address passes two states: the page map
// read in the accept cycle (ST_IDLE), then the buffer compare, the decision and the
// write-back in ST_LOOKUP; the next address is taken only once ST_LOOKUP is left. The
// output register lets a new address come in while a result still waits on the master
// side; ST_LOOKUP is held only while that earlier result is still not taken.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] virtual_address
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] physical_address
    output logic [1:0]  o_m_axis_tuser    // [0] tlb_hit, [1] fault
);
    import tlbpt_pkg::*;

    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);

    // control
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_done;

    // item in flight
    logic [VA_W-1:0]     r_va;
    logic [PAGE_W-1:0]   w_page;
    logic [OFFSET_W-1:0] w_offset;

    // translation buffer bookkeeping
    logic [FILL_W-1:0]   r_fill_count;
    logic [FRAME_W-1:0]  r_next_frame;
    logic                w_tlb_full;
    logic                w_insert;

    // cell row
    t_cell_ctl           w_ctl     [TLB_ENTRIES];
    t_xlat_entry         w_cell_in [TLB_ENTRIES];
    t_xlat_entry         w_cell_out[TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] w_cell_hit;
    logic [FRAME_W-1:0]  w_cell_frame[TLB_ENTRIES];
    t_xlat_entry         w_new_entry;

    // lookup result
    logic                w_tlb_hit;
    logic [FRAME_W-1:0]  w_tlb_frame;
    logic                w_map_valid;
    logic [FRAME_W-1:0]  w_map_frame;
    logic                w_fault;
    logic [FRAME_W-1:0]  w_frame;

    // output register
    logic                r_out_valid;
    logic [PA_W-1:0]     r_out_addr;
    logic [1:0]          r_out_user;

    assign w_page   = r_va[VA_W-1:OFFSET_W];
    assign w_offset = r_va[OFFSET_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_accept        = 1'b0;
        w_done          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_accept        = i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // finish once the output register is free or being drained
                w_done = !r_out_valid || i_m_axis_tready;
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold the address of the transfer in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va <= i_s_axis_tdata;
        end
    end

    // page map, read in the accept cycle
    tlbpt_page_map u_page_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_page  (i_s_axis_tdata[OFFSET_W +: PAGE_IDX_W]),
        .o_rd_valid (w_map_valid),
        .o_rd_frame (w_map_frame),
        .i_wr_en    (w_done && w_fault),
        .i_wr_page  (w_page[PAGE_IDX_W-1:0]),
        .i_wr_frame (r_next_frame)
    );

    // cell row: cell 0 takes the new entry, each other cell its left neighbor
    assign w_new_entry.tag   = w_page;
    assign w_new_entry.frame = w_frame;

    genvar g;
    generate
        for (g = 0; g < TLB_ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_cell_in[g] = w_new_entry;
            end else begin : g_body
                assign w_cell_in[g] = w_cell_out[g-1];
            end
            assign w_ctl[g].shift = w_insert;
            assign w_ctl[g].valid = (r_fill_count > FILL_W'(g));

            tlbpt_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_key   (w_page),
                .i_entry (w_cell_in[g]),
                .o_entry (w_cell_out[g]),
                .o_hit   (w_cell_hit[g]),
                .o_frame (w_cell_frame[g])
            );
        end
    endgenerate

    // live entries never repeat a page, so at most one cell hits
    always_comb begin
        w_tlb_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_tlb_frame = w_tlb_frame | w_cell_frame[i];
        end
    end
    assign w_tlb_hit = |w_cell_hit;

    // hit, mapped miss, or fault with a fresh frame
    assign w_fault = !w_tlb_hit && !w_map_valid;
    always_comb begin
        if (w_tlb_hit) begin
            w_frame = w_tlb_frame;
        end else if (w_map_valid) begin
            w_frame = w_map_frame;
        end else begin
            w_frame = r_next_frame;
        end
    end

    assign w_tlb_full = (r_fill_count == FILL_W'(TLB_ENTRIES));
    assign w_insert   = w_done && !w_tlb_hit;

    // fill count and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= '0;
            r_next_frame <= '0;
        end else begin
            if (w_insert && !w_tlb_full) begin
                r_fill_count <= r_fill_count + FILL_W'(1);
            end
            if (w_done && w_fault) begin
                r_next_frame <= r_next_frame + FRAME_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_addr <= {w_frame, w_offset};
            r_out_user <= {w_fault, w_tlb_hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_user;

endmodule

@@ bench/tlb_page_table_translator_test.sv @@
`timescale 1ns / 1ps

module tlb_page_table_translator_test;
    import tlbpt_pkg::*;

    localparam int TLB_DEPTH    = TLB_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 680;
    localparam int IDLE_PERCENT = 11;
    localparam int STALL_LIMIT  = 5000;

    // one translation as it leaves the block
    typedef struct packed {
        logic [PA_W-1:0] phys_addr;
        logic            hit;
        logic            fault;
    } t_translation;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [VA_W-1:0]   s_data = '0;
    logic              m_ready = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [PA_W-1:0]   m_data;   // [15:0] physical_address
    logic [1:0]        m_user;   // [0] tlb_hit, [1] fault

    tlb_page_table_translator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    // shadow of the translator state
    bit                 map_valid [PAGE_COUNT];
    logic [FRAME_W-1:0] map_frame [PAGE_COUNT];
    logic [PAGE_W-1:0]  buf_tag [TLB_DEPTH];
    logic [FRAME_W-1:0] buf_frame [TLB_DEPTH];
    int unsigned        buf_used = 0;
    int unsigned        buf_oldest = 0;
    logic [FRAME_W-1:0] frame_counter = '0;
    logic [PAGE_W-1:0]  mapped_pages [$];

    t_translation pending_translations [$];

    int unsigned error_count = 0;
    int unsigned sent_total = 0;
    int unsigned hit_total = 0;
    int unsigned refill_total = 0;
    int unsigned fault_total = 0;
    int unsigned evict_total = 0;
    int unsigned wrap_total = 0;
    int unsigned stall_cycles = 0;
    bit          steady = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void buffer_insert(input logic [PAGE_W-1:0] page,
                                          input logic [FRAME_W-1:0] frame);
        int unsigned slot;
        if (buf_used < TLB_DEPTH) begin
            slot = buf_used;
            buf_used++;
        end else begin
            // full: the oldest entry goes
            slot = buf_oldest;
            buf_oldest = (slot + 1) % TLB_DEPTH;
            evict_total++;
        end
        buf_tag[slot] = page;
        buf_frame[slot] = frame;
    endfunction

    function automatic t_translation translate_address(input logic [VA_W-1:0] va);
        t_translation       t;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        bit                 found;
        int unsigned        i;
        page = va[VA_W-1 -: PAGE_W];
        frame = '0;
        found = 1'b0;
        for (i = 0; i < buf_used; i++) begin
            if (!found && buf_tag[i] == page) begin
                found = 1'b1;
                frame = buf_frame[i];
            end
        end
        t.hit = found;
        t.fault = 1'b0;
        if (found) begin
            hit_total++;
        end else if (map_valid[page]) begin
            frame = map_frame[page];
            refill_total++;
            buffer_insert(page, frame);
        end else begin
            // no mapping: take the next frame, counter wraps at 256
            t.fault = 1'b1;
            frame = frame_counter;
            frame_counter = frame_counter + 1'b1;
            if (frame_counter == '0) begin
                wrap_total++;
            end
            map_valid[page] = 1'b1;
            map_frame[page] = frame;
            mapped_pages.push_back(page);
            fault_total++;
            buffer_insert(page, frame);
        end
        t.phys_addr = {frame, va[OFFSET_W-1:0]};
        return t;
    endfunction

    // called just after a falling edge; returns just after the falling edge past the transfer
    task automatic send_address(input logic [VA_W-1:0] va);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= va;
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        pending_translations.push_back(translate_address(va));
        sent_total++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_translations.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // receiver side backpressure
    always @(negedge i_clk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_translation got;
        t_translation want;
        if (i_rst_n && m_valid && m_ready) begin
            got.phys_addr = m_data;
            got.hit = m_user[0];
            got.fault = m_user[1];
            if (pending_translations.size() == 0) begin
                $display("%0t: unexpected transfer, actual pa=%h hit=%b fault=%b",
                         $time, got.phys_addr, got.hit, got.fault);
                error_count++;
            end else begin
                want = pending_translations.pop_front();
                if (got.phys_addr !== want.phys_addr) begin
                    $display("%0t: physical_address expected %h actual %h",
                             $time, want.phys_addr, got.phys_addr);
                    error_count++;
                end
                if (got.hit !== want.hit) begin
                    $display("%0t: tlb_hit expected %b actual %b",
                             $time, want.hit, got.hit);
                    error_count++;
                end
                if (got.fault !== want.fault) begin
                    $display("%0t: fault flag expected %b actual %b",
                             $time, want.fault, got.fault);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_translations.size());
            $display("simulation failed");
            $finish;
        end
    end

    // first touches, hits on both ends of the address range
    task automatic test_first_touch();
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
    endtask

    // fill the buffer, evict the oldest, then refill a page from the map
    task automatic test_buffer_eviction();
        int p;
        for (p = 1; p <= 16; p++) begin
            send_address({p[PAGE_W-1:0], 8'h5A ^ p[7:0]});
        end
        send_address(16'h0080);
        send_address(16'h10A5);
        send_address(16'hFF7F);
    endtask

    // mostly working-set traffic with random offsets, some cold pages
    task automatic test_random_traffic();
        int                n;
        int unsigned       roll;
        logic [PAGE_W-1:0] page;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 420);
            if (n == 500) begin
                drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 50 && buf_used != 0) begin
                page = buf_tag[$urandom_range(0, buf_used - 1)];
            end else if (roll < 75 && mapped_pages.size() != 0) begin
                page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            end else begin
                page = 8'($urandom_range(0, 255));
            end
            send_address({page, 8'($urandom_range(0, 255))});
        end
        steady = 1'b0;
    endtask

    // fault every page still unmapped so the frame counter goes all the way round
    task automatic test_frame_wrap();
        int p;
        for (p = 0; p < PAGE_COUNT; p++) begin
            if (!map_valid[p]) begin
                send_address({p[PAGE_W-1:0], 8'($urandom_range(0, 255))});
            end
        end
        send_address(16'h0001);
        send_address(16'hFFFE);
        send_address(16'h7F80);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_touch();
        test_buffer_eviction();
        test_random_traffic();
        test_frame_wrap();

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("%0d translations: %0d buffer hits, %0d map refills, %0d new-frame faults",
                 sent_total, hit_total, refill_total, fault_total);
        $display("%0d buffer evictions, frame counter wrapped %0d time(s)",
                 evict_total, wrap_total);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
